FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ABB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ABB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/abb_pkg.sv
`default_nettype none

package abb_pkg;

    localparam int COORD_BITS     = 20;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int MAG_BITS       = TRIG_FRAC_BITS + 1;
    localparam int POS_BITS       = COORD_BITS + 2;
    localparam int OUT_BITS       = COORD_BITS + 3;
    localparam int ANGLE_BITS     = 9;
    localparam int SWEEP_BITS     = 10;
    localparam int END_BITS       = SWEEP_BITS + 1;
    localparam int WIDTH_BITS     = 9;
    localparam int HALF_BITS      = WIDTH_BITS - 1;
    localparam int REM_BITS       = 7;
    localparam int THR_BITS       = 10;
    localparam int PIPE_STAGES    = 7;
    localparam int NUM_SIDES      = 4;
    localparam int QUARTER_DEG    = 90;
    localparam int SERIES_TERMS   = 13;

    localparam logic [ANGLE_BITS-1:0] DEG_90  = ANGLE_BITS'(90);
    localparam logic [ANGLE_BITS-1:0] DEG_180 = ANGLE_BITS'(180);
    localparam logic [ANGLE_BITS-1:0] DEG_270 = ANGLE_BITS'(270);
    localparam logic [ANGLE_BITS-1:0] DEG_360 = ANGLE_BITS'(360);

    localparam logic signed [SWEEP_BITS-1:0] SWEEP_MAX = SWEEP_BITS'(360);
    localparam logic signed [SWEEP_BITS-1:0] SWEEP_MIN = -SWEEP_BITS'(360);
    localparam logic signed [END_BITS-1:0]   FULL_TURN = END_BITS'(360);

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

    typedef logic [1:0] quadrant_t;

    // box sides, in the order the axis crossings visit them
    localparam quadrant_t SIDE_RIGHT  = 2'd0;
    localparam quadrant_t SIDE_BOTTOM = 2'd1;
    localparam quadrant_t SIDE_LEFT   = 2'd2;
    localparam quadrant_t SIDE_TOP    = 2'd3;

    typedef struct packed {
        quadrant_t             q;
        logic [REM_BITS-1:0]   r;
    } quad_split_t;

    typedef struct packed {
        logic [MAG_BITS-1:0] sin_mag;
        logic                sin_neg;
        logic [MAG_BITS-1:0] cos_mag;
        logic                cos_neg;
    } trig_t;

    typedef logic [MAG_BITS-1:0] sine_table_t [0:QUARTER_DEG];

    function automatic quad_split_t split_quadrant(input logic [ANGLE_BITS-1:0] d);
        quad_split_t s;
        if (d >= DEG_270)
        begin
            s.q = 2'd3;
            s.r = REM_BITS'(d - DEG_270);
        end
        else if (d >= DEG_180)
        begin
            s.q = 2'd2;
            s.r = REM_BITS'(d - DEG_180);
        end
        else if (d >= DEG_90)
        begin
            s.q = 2'd1;
            s.r = REM_BITS'(d - DEG_90);
        end
        else
        begin
            s.q = 2'd0;
            s.r = REM_BITS'(d);
        end
        return s;
    endfunction

    // (a * b) >> 61 on unsigned q3.61 values
    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // taylor term divisor (2n)(2n+1)
    function automatic logic [63:0] series_div(input logic [63:0] t, input int n);
        case (n)
            1:       return t / 64'd6;
            2:       return t / 64'd20;
            3:       return t / 64'd42;
            4:       return t / 64'd72;
            5:       return t / 64'd110;
            6:       return t / 64'd156;
            7:       return t / 64'd210;
            8:       return t / 64'd272;
            9:       return t / 64'd342;
            10:      return t / 64'd420;
            11:      return t / 64'd506;
            12:      return t / 64'd600;
            13:      return t / 64'd702;
            default: return t;
        endcase
    endfunction

    function automatic logic [MAG_BITS-1:0] sine_quarter(input int k);
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        kk   = 64'(k);
        x    = (PI_Q61 / 64'd180) * kk + ((PI_Q61 % 64'd180) * kk) / 64'd180;
        x2   = mul_q61(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = series_div(mul_q61(term, x2), n);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        sum = (sum + (64'd1 << (60 - TRIG_FRAC_BITS))) >> (61 - TRIG_FRAC_BITS);
        return sum[MAG_BITS-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        for (int k = 0; k <= QUARTER_DEG; k++)
        begin
            t[k] = sine_quarter(k);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

FILE: hdl/abb_sine_unit.sv
`default_nettype none

module abb_sine_unit (
    input  wire logic                             clk,
    input  wire logic                             en_split,
    input  wire logic                             en_read,
    input  wire logic [abb_pkg::ANGLE_BITS-1:0]   angle,
    output abb_pkg::trig_t                        trig
);

    abb_pkg::quad_split_t           split_reg;
    abb_pkg::quad_split_t           split_next;
    abb_pkg::trig_t                 trig_reg;
    abb_pkg::trig_t                 trig_next;
    logic [abb_pkg::REM_BITS-1:0]   idx_lo;
    logic [abb_pkg::REM_BITS-1:0]   idx_hi;

    assign split_next = abb_pkg::split_quadrant(angle);

    // cosine is the sine one quadrant further on
    always_comb
    begin
        idx_lo = split_reg.r;
        idx_hi = abb_pkg::REM_BITS'(abb_pkg::QUARTER_DEG) - split_reg.r;
        trig_next.sin_mag = split_reg.q[0] ? abb_pkg::SINE_TABLE[idx_hi]
                                           : abb_pkg::SINE_TABLE[idx_lo];
        trig_next.sin_neg = split_reg.q[1];
        trig_next.cos_mag = split_reg.q[0] ? abb_pkg::SINE_TABLE[idx_lo]
                                           : abb_pkg::SINE_TABLE[idx_hi];
        trig_next.cos_neg = split_reg.q[1] ^ split_reg.q[0];
    end

    always_ff @(posedge clk)
    begin
        if (en_split)
            split_reg <= split_next;
        if (en_read)
            trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

`default_nettype wire

FILE: hdl/arc_bounding_box.sv
// Bounding box of a stroked circular arc, one arc item per clock through a seven-stage
// pipeline: angle normalization, quadrant split, sine table read, radius scaling (four
// 20x17 multipliers in one stage), end point placement, min/max with axis-crossing
// extension, and half-width padding into the output register. A box is presented from the
// output register once its arc has passed through every stage register in order; the
// sustained rate is one arc per cycle, and with box_ready low the stages behind the output
// register keep filling until all seven hold an item, after which arc_ready drops.
`default_nettype none

`include "assert_macros.svh"

module arc_bounding_box (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    arc_valid,
    output      logic                                    arc_ready,
    input  wire logic [abb_pkg::COORD_BITS-1:0]          center_x,
    input  wire logic [abb_pkg::COORD_BITS-1:0]          center_y,
    input  wire logic [abb_pkg::COORD_BITS-1:0]          radius,
    input  wire logic [abb_pkg::ANGLE_BITS-1:0]          arc_start,
    input  wire logic signed [abb_pkg::SWEEP_BITS-1:0]   sweep,
    input  wire logic [abb_pkg::WIDTH_BITS-1:0]          stroke_width,
    output      logic                                    box_valid,
    input  wire logic                                    box_ready,
    output      logic signed [abb_pkg::OUT_BITS-1:0]     box_left,
    output      logic signed [abb_pkg::OUT_BITS-1:0]     box_top,
    output      logic signed [abb_pkg::OUT_BITS-1:0]     box_right,
    output      logic signed [abb_pkg::OUT_BITS-1:0]     box_bottom
);

    localparam int STAGES = abb_pkg::PIPE_STAGES;
    localparam int PT_X2  = 0;
    localparam int PT_Y2  = 1;
    localparam int PT_X3  = 2;
    localparam int PT_Y3  = 3;

    typedef logic signed [abb_pkg::POS_BITS-1:0] pos_t;
    typedef logic signed [abb_pkg::OUT_BITS-1:0] out_t;
    typedef logic [abb_pkg::COORD_BITS-1:0]      coord_t;
    typedef logic [abb_pkg::ANGLE_BITS-1:0]      angle_t;
    typedef logic [abb_pkg::THR_BITS-1:0]        thr_t;
    typedef logic [abb_pkg::NUM_SIDES-1:0]       side_flags_t;

    typedef struct packed {
        coord_t                         cx;
        coord_t                         cy;
        coord_t                         rad;
        logic [abb_pkg::HALF_BITS-1:0]  half;
    } carry_t;

    function automatic pos_t min3(input pos_t a, input pos_t b, input pos_t c);
        pos_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic pos_t max3(input pos_t a, input pos_t b, input pos_t c);
        pos_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // crossing on this side lies strictly inside the counter-clockwise sweep
    function automatic logic crossing_hit(input abb_pkg::quadrant_t q0,
                                          input abb_pkg::quadrant_t side,
                                          input thr_t thr);
        abb_pkg::quadrant_t step;
        logic [2:0]         k;
        thr_t               deg;
        step = side - q0 - 2'd1;
        k    = {1'b0, q0} + {1'b0, step} + 3'd1;
        deg  = abb_pkg::THR_BITS'(k) * abb_pkg::THR_BITS'(abb_pkg::QUARTER_DEG);
        return deg < thr;
    endfunction

    function automatic coord_t scale(input coord_t rad, input logic [abb_pkg::MAG_BITS-1:0] mag);
        logic [abb_pkg::COORD_BITS+abb_pkg::MAG_BITS-1:0] p;
        p = (abb_pkg::COORD_BITS + abb_pkg::MAG_BITS)'(rad)
            * (abb_pkg::COORD_BITS + abb_pkg::MAG_BITS)'(mag);
        return p[abb_pkg::TRIG_FRAC_BITS +: abb_pkg::COORD_BITS];
    endfunction

    function automatic pos_t place(input coord_t c, input coord_t m, input logic neg);
        pos_t cp;
        pos_t mp;
        cp = abb_pkg::POS_BITS'(c);
        mp = abb_pkg::POS_BITS'(m);
        return neg ? cp - mp : cp + mp;
    endfunction

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    // stage 1
    carry_t                              s1_carry_reg, s1_carry_next;
    angle_t                              s1_start_reg, s1_start_next;
    angle_t                              s1_end_reg, s1_end_next;
    angle_t                              s1_ccw_reg, s1_ccw_next;
    angle_t                              s1_span_reg, s1_span_next;
    logic signed [abb_pkg::SWEEP_BITS-1:0] sw;
    logic signed [abb_pkg::SWEEP_BITS-1:0] sw_mag;
    logic signed [abb_pkg::END_BITS-1:0]   end_sum;
    logic signed [abb_pkg::END_BITS-1:0]   end_fix;

    // stage 2
    carry_t                s2_carry_reg;
    abb_pkg::quadrant_t    s2_q0_reg, s2_q0_next;
    thr_t                  s2_thr_reg, s2_thr_next;
    abb_pkg::quad_split_t  s2_split;

    // stage 3
    carry_t              s3_carry_reg;
    side_flags_t         s3_ext_reg, s3_ext_next;
    abb_pkg::trig_t      start_trig;
    abb_pkg::trig_t      end_trig;

    // stage 4
    carry_t              s4_carry_reg;
    side_flags_t         s4_ext_reg;
    coord_t              s4_mag_reg [4];
    coord_t              s4_mag_next [4];
    logic [3:0]          s4_neg_reg, s4_neg_next;

    // stage 5
    carry_t              s5_carry_reg;
    side_flags_t         s5_ext_reg;
    pos_t                s5_pt_reg [4];
    pos_t                s5_pt_next [4];

    // stage 6
    logic [abb_pkg::HALF_BITS-1:0] s6_half_reg;
    pos_t                s6_bound_reg [abb_pkg::NUM_SIDES];
    pos_t                s6_bound_next [abb_pkg::NUM_SIDES];
    pos_t                cxs, cys, rads;

    // stage 7
    out_t                box_left_reg, box_left_next;
    out_t                box_top_reg, box_top_next;
    out_t                box_right_reg, box_right_next;
    out_t                box_bottom_reg, box_bottom_next;
    out_t                half_o;

    // stall chain: a stage loads when it is empty or the one after it moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || box_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? arc_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign arc_ready = adv[0];
    assign box_valid = vld_reg[STAGES-1];

    // stage 1: normalize angles, clamp sweep, mirror clockwise arcs
    always_comb
    begin
        s1_start_next = (arc_start >= abb_pkg::DEG_360) ? arc_start - abb_pkg::DEG_360
                                                        : arc_start;
        if (sweep > abb_pkg::SWEEP_MAX)
            sw = abb_pkg::SWEEP_MAX;
        else if (sweep < abb_pkg::SWEEP_MIN)
            sw = abb_pkg::SWEEP_MIN;
        else
            sw = sweep;
        end_sum = $signed({2'b00, s1_start_next}) + $signed({sw[abb_pkg::SWEEP_BITS-1], sw});
        if (end_sum < 0)
            end_fix = end_sum + abb_pkg::FULL_TURN;
        else if (end_sum >= abb_pkg::FULL_TURN)
            end_fix = end_sum - abb_pkg::FULL_TURN;
        else
            end_fix = end_sum;
        s1_end_next  = end_fix[abb_pkg::ANGLE_BITS-1:0];
        s1_ccw_next  = sw[abb_pkg::SWEEP_BITS-1] ? s1_end_next : s1_start_next;
        sw_mag       = sw[abb_pkg::SWEEP_BITS-1] ? -sw : sw;
        s1_span_next = sw_mag[abb_pkg::ANGLE_BITS-1:0];
        s1_carry_next.cx   = center_x;
        s1_carry_next.cy   = center_y;
        s1_carry_next.rad  = radius;
        s1_carry_next.half = stroke_width[abb_pkg::WIDTH_BITS-1:1];
    end

    // stage 2: quadrant of the sweep start, sweep end threshold
    always_comb
    begin
        s2_split    = abb_pkg::split_quadrant(s1_ccw_reg);
        s2_q0_next  = s2_split.q;
        s2_thr_next = abb_pkg::THR_BITS'(s1_ccw_reg) + abb_pkg::THR_BITS'(s1_span_reg);
    end

    abb_sine_unit u_start_trig (
        .clk      (clk),
        .en_split (adv[1]),
        .en_read  (adv[2]),
        .angle    (s1_start_reg),
        .trig     (start_trig)
    );

    abb_sine_unit u_end_trig (
        .clk      (clk),
        .en_split (adv[1]),
        .en_read  (adv[2]),
        .angle    (s1_end_reg),
        .trig     (end_trig)
    );

    // stage 3: axis crossings per side
    always_comb
    begin
        for (int s = 0; s < abb_pkg::NUM_SIDES; s++)
        begin
            s3_ext_next[s] = crossing_hit(s2_q0_reg, abb_pkg::quadrant_t'(s), s2_thr_reg);
        end
    end

    // stage 4: radius times cosine and sine
    always_comb
    begin
        s4_mag_next[PT_X2] = scale(s3_carry_reg.rad, start_trig.cos_mag);
        s4_mag_next[PT_Y2] = scale(s3_carry_reg.rad, start_trig.sin_mag);
        s4_mag_next[PT_X3] = scale(s3_carry_reg.rad, end_trig.cos_mag);
        s4_mag_next[PT_Y3] = scale(s3_carry_reg.rad, end_trig.sin_mag);
        s4_neg_next[PT_X2] = start_trig.cos_neg;
        s4_neg_next[PT_Y2] = start_trig.sin_neg;
        s4_neg_next[PT_X3] = end_trig.cos_neg;
        s4_neg_next[PT_Y3] = end_trig.sin_neg;
    end

    // stage 5: end points
    always_comb
    begin
        s5_pt_next[PT_X2] = place(s4_carry_reg.cx, s4_mag_reg[PT_X2], s4_neg_reg[PT_X2]);
        s5_pt_next[PT_Y2] = place(s4_carry_reg.cy, s4_mag_reg[PT_Y2], s4_neg_reg[PT_Y2]);
        s5_pt_next[PT_X3] = place(s4_carry_reg.cx, s4_mag_reg[PT_X3], s4_neg_reg[PT_X3]);
        s5_pt_next[PT_Y3] = place(s4_carry_reg.cy, s4_mag_reg[PT_Y3], s4_neg_reg[PT_Y3]);
    end

    // stage 6: box of center and end points, pushed out at crossings
    always_comb
    begin
        cxs  = abb_pkg::POS_BITS'(s5_carry_reg.cx);
        cys  = abb_pkg::POS_BITS'(s5_carry_reg.cy);
        rads = abb_pkg::POS_BITS'(s5_carry_reg.rad);
        s6_bound_next[abb_pkg::SIDE_RIGHT] = s5_ext_reg[abb_pkg::SIDE_RIGHT] ? cxs + rads
            : max3(cxs, s5_pt_reg[PT_X2], s5_pt_reg[PT_X3]);
        s6_bound_next[abb_pkg::SIDE_BOTTOM] = s5_ext_reg[abb_pkg::SIDE_BOTTOM] ? cys + rads
            : max3(cys, s5_pt_reg[PT_Y2], s5_pt_reg[PT_Y3]);
        s6_bound_next[abb_pkg::SIDE_LEFT] = s5_ext_reg[abb_pkg::SIDE_LEFT] ? cxs - rads
            : min3(cxs, s5_pt_reg[PT_X2], s5_pt_reg[PT_X3]);
        s6_bound_next[abb_pkg::SIDE_TOP] = s5_ext_reg[abb_pkg::SIDE_TOP] ? cys - rads
            : min3(cys, s5_pt_reg[PT_Y2], s5_pt_reg[PT_Y3]);
    end

    // stage 7: half line width on every side
    always_comb
    begin
        half_o = abb_pkg::OUT_BITS'(s6_half_reg);
        box_left_next = {s6_bound_reg[abb_pkg::SIDE_LEFT][abb_pkg::POS_BITS-1],
                         s6_bound_reg[abb_pkg::SIDE_LEFT]} - half_o;
        box_top_next = {s6_bound_reg[abb_pkg::SIDE_TOP][abb_pkg::POS_BITS-1],
                        s6_bound_reg[abb_pkg::SIDE_TOP]} - half_o;
        box_right_next = {s6_bound_reg[abb_pkg::SIDE_RIGHT][abb_pkg::POS_BITS-1],
                          s6_bound_reg[abb_pkg::SIDE_RIGHT]} + half_o;
        box_bottom_next = {s6_bound_reg[abb_pkg::SIDE_BOTTOM][abb_pkg::POS_BITS-1],
                           s6_bound_reg[abb_pkg::SIDE_BOTTOM]} + half_o;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_carry_reg <= s1_carry_next;
            s1_start_reg <= s1_start_next;
            s1_end_reg   <= s1_end_next;
            s1_ccw_reg   <= s1_ccw_next;
            s1_span_reg  <= s1_span_next;
        end
        if (adv[1])
        begin
            s2_carry_reg <= s1_carry_reg;
            s2_q0_reg    <= s2_q0_next;
            s2_thr_reg   <= s2_thr_next;
        end
        if (adv[2])
        begin
            s3_carry_reg <= s2_carry_reg;
            s3_ext_reg   <= s3_ext_next;
        end
        if (adv[3])
        begin
            s4_carry_reg <= s3_carry_reg;
            s4_ext_reg   <= s3_ext_reg;
            s4_mag_reg   <= s4_mag_next;
            s4_neg_reg   <= s4_neg_next;
        end
        if (adv[4])
        begin
            s5_carry_reg <= s4_carry_reg;
            s5_ext_reg   <= s4_ext_reg;
            s5_pt_reg    <= s5_pt_next;
        end
        if (adv[5])
        begin
            s6_half_reg  <= s5_carry_reg.half;
            s6_bound_reg <= s6_bound_next;
        end
        if (adv[6])
        begin
            box_left_reg   <= box_left_next;
            box_top_reg    <= box_top_next;
            box_right_reg  <= box_right_next;
            box_bottom_reg <= box_bottom_next;
        end
    end

    assign box_left   = box_left_reg;
    assign box_top    = box_top_reg;
    assign box_right  = box_right_reg;
    assign box_bottom = box_bottom_reg;

    `ABB_ASSERT_IMPLY(a_box_x_order, clk, rst_n, box_valid, box_left <= box_right, "box left beyond right")
    `ABB_ASSERT_IMPLY(a_box_y_order, clk, rst_n, box_valid, box_top <= box_bottom, "box top beyond bottom")
    `ABB_ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, !box_valid, arc_ready, "pipeline blocked while output empty")
    `ABB_ASSERT_NEXT(a_fill_count, clk, rst_n, arc_valid && arc_ready && !(box_valid && box_ready), $countones(vld_reg) == $past($countones(vld_reg)) + 1, "accepted item not tracked")
    `ABB_ASSERT_IMPLY(a_scale_bound, clk, rst_n, vld_reg[3], s4_mag_reg[PT_X2] <= s4_carry_reg.rad && s4_mag_reg[PT_Y3] <= s4_carry_reg.rad, "scaled offset exceeds radius")

endmodule

`default_nettype wire
